// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the media packet header parser.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define MPHP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the cycle after.
`define MPHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/mphp_pkg.sv
// Package for the media packet header parser: parse phases, state and result
// types, and the field size helpers. Depends on nothing.
package mphp_pkg;

  typedef enum logic [8:0] {
    PH_IDLE  = 9'b0_0000_0001,
    PH_SKIP  = 9'b0_0000_0010,
    PH_LTYPE = 9'b0_0000_0100,
    PH_PROP  = 9'b0_0000_1000,
    PH_PLEN  = 9'b0_0001_0000,
    PH_SEQ   = 9'b0_0010_0000,
    PH_PAD   = 9'b0_0100_0000,
    PH_SEND  = 9'b0_1000_0000,
    PH_DUR   = 9'b1_0000_0000
  } phase_t;

  localparam logic [2:0] SIZE_OF_TYPE [4] = '{3'd0, 3'd1, 3'd2, 3'd4};
  localparam logic [2:0] SEND_SIZE = 3'd4;
  localparam logic [2:0] DUR_SIZE  = 3'd2;
  localparam logic [5:0] COUNT_MAX = 6'd63;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  left;
    logic [7:0]  ecc;
    logic [7:0]  lflags;
    logic [7:0]  pflags;
    logic [31:0] plen;
    logic [31:0] seq;
    logic [31:0] pad;
    logic [31:0] send;
    logic [15:0] dur;
    logic [5:0]  count;
  } parse_state_t;

  typedef struct packed {
    logic [5:0]  header_bytes;
    logic [15:0] duration;
    logic [31:0] send_ms;
    logic [31:0] pad_len;
    logic [31:0] sequence_value;
    logic [31:0] pkt_len;
    logic [7:0]  prop_flags;
    logic [7:0]  length_flags;
    logic [7:0]  ecc_flags;
  } header_result_t;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] left;
  } field_entry_t;

  // Byte count of a field phase under the given length-type byte.
  function automatic logic [2:0] field_size(phase_t ph, logic [7:0] lf);
    logic [2:0] sz;
    sz = 3'd0;
    case (ph)
      PH_PLEN: sz = SIZE_OF_TYPE[lf[6:5]];
      PH_SEQ:  sz = SIZE_OF_TYPE[lf[2:1]];
      PH_PAD:  sz = SIZE_OF_TYPE[lf[4:3]];
      PH_SEND: sz = SEND_SIZE;
      PH_DUR:  sz = DUR_SIZE;
      default: sz = 3'd0;
    endcase
    return sz;
  endfunction

  // Phase that follows a field phase.
  function automatic phase_t following_field(phase_t ph);
    phase_t nx;
    nx = PH_IDLE;
    unique case (ph)
      PH_PLEN: nx = PH_SEQ;
      PH_SEQ:  nx = PH_PAD;
      PH_PAD:  nx = PH_SEND;
      PH_SEND: nx = PH_DUR;
      default: nx = PH_IDLE;
    endcase
    return nx;
  endfunction

  // First field at or after ph that carries bytes; send time always does.
  function automatic field_entry_t enter_field(phase_t ph, logic [7:0] lf);
    field_entry_t e;
    logic         from_plen;
    logic         from_seq;
    logic         from_pad;
    from_plen = (ph == PH_PLEN);
    from_seq  = from_plen || (ph == PH_SEQ);
    from_pad  = from_seq || (ph == PH_PAD);
    if (from_plen && field_size(PH_PLEN, lf) != 3'd0) begin
      e.phase = PH_PLEN;
    end else if (from_seq && field_size(PH_SEQ, lf) != 3'd0) begin
      e.phase = PH_SEQ;
    end else if (from_pad && field_size(PH_PAD, lf) != 3'd0) begin
      e.phase = PH_PAD;
    end else if (ph == PH_DUR) begin
      e.phase = PH_DUR;
    end else begin
      e.phase = PH_SEND;
    end
    e.left = {1'b0, field_size(e.phase, lf)};
    return e;
  endfunction

endpackage

// File: hw/rtl/mphp_step.sv
// Next-state logic of the header parser for one byte, and the header result
// when that byte completes it. Depends on mphp_pkg.
module mphp_step
  import mphp_pkg::*;
(
  input  parse_state_t   st,
  input  logic [7:0]     data_byte,
  input  logic           first_of_packet,
  output parse_state_t   st_next,
  output logic           done,
  output header_result_t result
);

  logic [2:0]   cur_size;
  logic [1:0]   pos;
  logic [31:0]  lane;
  logic [3:0]   left_dec;
  field_entry_t entry;

  assign cur_size = field_size(st.phase, st.lflags);
  assign pos      = 2'(cur_size - st.left[2:0]);
  assign lane     = 32'(data_byte) << {pos, 3'b000};
  assign left_dec = st.left - 4'd1;

  always_comb begin
    st_next = st;
    done    = 1'b0;
    entry   = enter_field(PH_PLEN, st.lflags);
    if (first_of_packet) begin
      // Restart: clear every field, take this byte as the ECC flags
      st_next.ecc    = data_byte;
      st_next.lflags = '0;
      st_next.pflags = '0;
      st_next.plen   = '0;
      st_next.seq    = '0;
      st_next.pad    = '0;
      st_next.send   = '0;
      st_next.dur    = '0;
      st_next.count  = 6'd1;
      if (data_byte[7] && data_byte[3:0] != 4'd0) begin
        st_next.phase = PH_SKIP;
        st_next.left  = data_byte[3:0];
      end else begin
        st_next.phase = PH_LTYPE;
        st_next.left  = '0;
      end
    end else if (st.phase != PH_IDLE) begin
      if (st.count < COUNT_MAX) st_next.count = st.count + 6'd1;
      unique case (st.phase)
        PH_SKIP: begin
          st_next.left = left_dec;
          if (left_dec == 4'd0) st_next.phase = PH_LTYPE;
        end
        PH_LTYPE: begin
          st_next.lflags = data_byte;
          st_next.phase  = PH_PROP;
        end
        PH_PROP: begin
          st_next.pflags = data_byte;
          entry          = enter_field(PH_PLEN, st.lflags);
          st_next.phase  = entry.phase;
          st_next.left   = entry.left;
        end
        PH_PLEN, PH_SEQ, PH_PAD, PH_SEND, PH_DUR: begin
          unique case (st.phase)
            PH_PLEN: st_next.plen = st.plen | lane;
            PH_SEQ:  st_next.seq  = st.seq | lane;
            PH_PAD:  st_next.pad  = st.pad | lane;
            PH_SEND: st_next.send = st.send | lane;
            default: st_next.dur  = st.dur | (16'(data_byte) << {pos[0], 3'b000});
          endcase
          st_next.left = left_dec;
          if (left_dec == 4'd0) begin
            if (st.phase == PH_DUR) begin
              done          = 1'b1;
              st_next.phase = PH_IDLE;
            end else begin
              entry         = enter_field(following_field(st.phase), st.lflags);
              st_next.phase = entry.phase;
              st_next.left  = entry.left;
            end
          end
        end
        default: st_next.phase = PH_IDLE;
      endcase
    end
  end

  assign result.ecc_flags      = st_next.ecc;
  assign result.length_flags   = st_next.lflags;
  assign result.prop_flags     = st_next.pflags;
  assign result.pkt_len        = st_next.plen;
  assign result.sequence_value = st_next.seq;
  assign result.pad_len        = st_next.pad;
  assign result.send_ms        = st_next.send;
  assign result.duration       = st_next.dur;
  assign result.header_bytes   = st_next.count;

endmodule

// File: hw/rtl/media_packet_header_parser_core.sv
// Top level of the media packet header parser: parse state register, output
// register and assertions. Depends on mphp_pkg, mphp_step and assert_macros.svh.
`include "assert_macros.svh"

// Packet bytes stream in on the slave side, one per transaction, with tuser
// set on the first byte of a packet; that byte restarts the parse whatever
// was in progress. The header layout is the ECC flag byte (plus an optional
// skip of up to 15 bytes given by its low nibble), the length-type byte, the
// property byte, the packet length, sequence and padding fields of 0, 1, 2 or
// 4 little-endian bytes each, a 4-byte send time and a 2-byte duration. The
// transaction that carries the last duration byte yields one result on the
// master side: every field plus the header length in bytes. Bytes outside a
// header are consumed and dropped. The block takes one byte per cycle: the
// parse state advances in a single register update per byte, and the result
// sits in an output register so later bytes keep flowing while it waits.
// Input stalls only while the parse waits for the last duration byte and the
// previous result is still held by the downstream side. m_tvalid rises in the
// cycle after the last duration byte is accepted.
module media_packet_header_parser_core
  import mphp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,  // [7:0] data_byte
  input  logic         s_tuser,  // [0] first_of_packet
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [175:0] m_tdata   // [7:0] ecc_flags, [15:8] length_flags,
                                 // [23:16] prop_flags, [55:24] pkt_len,
                                 // [87:56] sequence_value, [119:88] pad_len,
                                 // [151:120] send_ms, [167:152] duration,
                                 // [173:168] header_bytes, [175:174] zero
);

  parse_state_t   st;
  parse_state_t   st_next;
  logic           step_done;
  header_result_t step_result;
  header_result_t result;
  logic           s_accept;
  logic           may_finish;
  logic           load_result;
  logic           needs_left;

  mphp_step u_step (
    .st              (st),
    .data_byte       (s_tdata),
    .first_of_packet (s_tuser),
    .st_next         (st_next),
    .done            (step_done),
    .result          (step_result)
  );

  // A byte can only complete a header on the final duration byte; hold input
  // then if the output register cannot take a new result.
  assign may_finish  = (st.phase == PH_DUR) && (st.left == 4'd1);
  assign s_tready    = !m_tvalid || m_tready || !may_finish;
  assign s_accept    = s_tvalid && s_tready;
  assign load_result = s_accept && step_done;
  // Skip and field phases count bytes down; the others hold no count
  assign needs_left  = !(st.phase == PH_IDLE || st.phase == PH_LTYPE ||
                         st.phase == PH_PROP);

  // Parse state: advance on every accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase  <= PH_IDLE;
      st.left   <= '0;
      st.ecc    <= '0;
      st.lflags <= '0;
      st.pflags <= '0;
      st.plen   <= '0;
      st.seq    <= '0;
      st.pad    <= '0;
      st.send   <= '0;
      st.dur    <= '0;
      st.count  <= '0;
    end else if (s_accept) begin
      st <= st_next;
    end
  end

  // Output register: load on a finished header, drop once taken downstream
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_result) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) result <= step_result;
  end

  assign m_tdata = {2'b00,
                    result.header_bytes,
                    result.duration,
                    result.send_ms,
                    result.pad_len,
                    result.sequence_value,
                    result.pkt_len,
                    result.prop_flags,
                    result.length_flags,
                    result.ecc_flags};

  // A finished header must never land on a result still waiting downstream
  `MPHP_ASSERT_ALWAYS(a_no_overwrite, !load_result || !m_tvalid || m_tready, "result overwritten")
  // A finished header shows up on the master side in the next cycle
  `MPHP_ASSERT_NEXT(a_result_shown, load_result, m_tvalid, "finished header not presented")
  // Skip and field phases always have bytes left to take
  `MPHP_ASSERT_ALWAYS(a_left_nonzero, !needs_left || st.left != 4'd0, "no bytes left in field")

endmodule
